// File: hw/rtl/utf8s_pkg.sv
package utf8s_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } utf8s_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       from_replacement;
        logic       run_last;
        logic       string_end;
    } utf8s_out_t;

    typedef enum logic [1:0] {
        DEC_STOP,
        DEC_PASS,
        DEC_REPL,
        DEC_SEQ
    } utf8s_dec_t;

    typedef enum logic [1:0] {
        SRC_BUF,
        SRC_EF,
        SRC_BF,
        SRC_BD
    } utf8s_src_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        utf8s_src_t src;
        logic       shift;
        logic       flush;
        logic       pass_load;
        logic       pass_dec;
    } utf8s_cmd_t;

    typedef struct packed {
        utf8s_dec_t dec;
        logic       adv;
        logic       pass_last;
    } utf8s_stat_t;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if (c < 8'h80) begin
            len = 3'd1;
        end else if (c inside {[8'hC2:8'hDF]}) begin
            len = 3'd2;
        end else if (c inside {[8'hE0:8'hEF]}) begin
            len = 3'd3;
        end else if (c inside {[8'hF0:8'hF4]}) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] k,
                                     input logic [7:0] b);
        logic ok;
        ok = (b[7:6] == 2'b10);
        if (k == 2'd1) begin
            if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
            if (lead == 8'hED && b >= 8'hA0) ok = 1'b0;
            if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
            if (lead == 8'hF4 && b >= 8'h90) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// File: hw/rtl/utf8s_datapath.sv
module utf8s_datapath
    import utf8s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  utf8s_in_t   s_data,
    input  logic        m_ready,
    output logic        m_valid,
    output utf8s_out_t  m_data,
    input  utf8s_cmd_t  cmd,
    output utf8s_stat_t stat
);

    logic [7:0] buf_reg [4];
    logic [7:0] buf_next [4];
    logic [2:0] cnt_reg, cnt_next;
    logic       final_reg, final_next;
    logic [1:0] pass_reg, pass_next;
    logic       stage_v_reg, stage_v_next;
    logic [7:0] stage_byte_reg, stage_byte_next;
    logic       stage_repl_reg, stage_repl_next;
    logic       m_valid_reg, m_valid_next;
    utf8s_out_t m_data_reg, m_data_next;

    logic       out_free;
    logic [2:0] len;
    logic [2:0] check;
    logic       bad;
    logic [7:0] src_byte;

    assign out_free = !m_valid_reg || m_ready;
    assign len      = lead_length(buf_reg[0]);
    assign check    = (cnt_reg < len) ? cnt_reg : len;

    always_comb begin
        bad = 1'b0;
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < check && !cont_ok(buf_reg[0], 2'(i), buf_reg[i])) bad = 1'b1;
        end
    end

    always_comb begin
        stat.adv       = !stage_v_reg || out_free;
        stat.pass_last = (pass_reg == 2'd1);
        if (cnt_reg == 3'd0) begin
            stat.dec = DEC_STOP;
        end else if (len == 3'd1) begin
            stat.dec = DEC_PASS;
        end else if (len == 3'd0 || bad) begin
            stat.dec = DEC_REPL;
        end else if (cnt_reg >= len) begin
            stat.dec = DEC_SEQ;
        end else if (final_reg) begin
            stat.dec = DEC_REPL;
        end else begin
            stat.dec = DEC_STOP;
        end
    end

    always_comb begin
        case (cmd.src)
            SRC_BUF: src_byte = buf_reg[0];
            SRC_EF:  src_byte = REPL_B0;
            SRC_BF:  src_byte = REPL_B1;
            SRC_BD:  src_byte = REPL_B2;
            default: src_byte = buf_reg[0];
        endcase
    end

    always_comb begin
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        final_next      = final_reg;
        pass_next       = pass_reg;
        stage_v_next    = stage_v_reg;
        stage_byte_next = stage_byte_reg;
        stage_repl_next = stage_repl_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (cmd.load) begin
            buf_next[cnt_reg[1:0]] = s_data.in_byte;
            cnt_next               = cnt_reg + 3'd1;
            final_next             = s_data.is_final;
        end
        if (cmd.shift) begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            buf_next[2] = buf_reg[3];
            buf_next[3] = 8'h00;
            cnt_next    = cnt_reg - 3'd1;
        end
        if (cmd.pass_load) begin
            pass_next = 2'(len - 3'd1);
        end else if (cmd.pass_dec) begin
            pass_next = pass_reg - 2'd1;
        end
        if (cmd.emit) begin
            if (stage_v_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = '{out_byte: stage_byte_reg, from_replacement: stage_repl_reg,
                                 run_last: 1'b0, string_end: 1'b0};
            end
            stage_v_next    = 1'b1;
            stage_byte_next = src_byte;
            stage_repl_next = (cmd.src != SRC_BUF);
        end
        if (cmd.flush && stage_v_reg) begin
            m_valid_next = 1'b1;
            m_data_next  = '{out_byte: stage_byte_reg, from_replacement: stage_repl_reg,
                             run_last: 1'b1, string_end: final_reg};
            stage_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) buf_reg[i] <= 8'h00;
            cnt_reg     <= 3'd0;
            final_reg   <= 1'b0;
            pass_reg    <= 2'd0;
            stage_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            final_reg   <= final_next;
            pass_reg    <= pass_next;
            stage_v_reg <= stage_v_next;
            m_valid_reg <= m_valid_next;
        end
        stage_byte_reg <= stage_byte_next;
        stage_repl_reg <= stage_repl_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/utf8s_ctrl.sv
module utf8s_ctrl
    import utf8s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  utf8s_stat_t stat,
    output utf8s_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REP1,
        ST_REP2,
        ST_PASS
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        cmd        = '0;
        cmd.src    = SRC_BUF;
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                    ready_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (stat.adv) begin
                    case (stat.dec)
                        DEC_STOP: begin
                            cmd.flush  = 1'b1;
                            state_next = ST_IDLE;
                            ready_next = 1'b1;
                        end
                        DEC_PASS: begin
                            cmd.emit  = 1'b1;
                            cmd.shift = 1'b1;
                        end
                        DEC_REPL: begin
                            cmd.emit   = 1'b1;
                            cmd.src    = SRC_EF;
                            cmd.shift  = 1'b1;
                            state_next = ST_REP1;
                        end
                        DEC_SEQ: begin
                            cmd.emit      = 1'b1;
                            cmd.shift     = 1'b1;
                            cmd.pass_load = 1'b1;
                            state_next    = ST_PASS;
                        end
                        default: ;
                    endcase
                end
            end
            ST_REP1: begin
                if (stat.adv) begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_BF;
                    state_next = ST_REP2;
                end
            end
            ST_REP2: begin
                if (stat.adv) begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_BD;
                    state_next = ST_SCAN;
                end
            end
            ST_PASS: begin
                if (stat.adv) begin
                    cmd.emit     = 1'b1;
                    cmd.shift    = 1'b1;
                    cmd.pass_dec = 1'b1;
                    if (stat.pass_last) state_next = ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

// File: hw/rtl/utf8_sanitizer.sv
// A word is accepted while idle. The scan controller then handles one decision or emitted
// byte per cycle unless stalled; m_ready low stalls the scan once the staging and output
// registers are both full. A closing step flushes the last byte and raises s_ready again,
// so the next word is not accepted before it.
// Reset: aresetn synchronous, active low; clears held bytes, count and output valid.
module utf8_sanitizer
    import utf8s_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  utf8s_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output utf8s_out_t m_data
);

    utf8s_cmd_t  cmd;
    utf8s_stat_t stat;

    utf8s_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    utf8s_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// File: bench/utf8_sanitizer_tb.sv
module testbench;
    import utf8s_pkg::*;

    localparam int WORD_TARGET = 330;
    localparam int CALM_AFTER  = 280;
    localparam int HOLD_AT     = 100;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 24;
    localparam int CYCLE_LIMIT = 400000;

    class utf8_scoreboard;
        logic [7:0] held[3];
        int         held_n;
        utf8s_out_t fresh[$];
        utf8s_out_t expected_q[$];
        int         errors;

        function new();
            held   = '{default: 8'h00};
            held_n = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction

        function int unsigned seq_len(logic [7:0] c);
            if (c < 8'h80) return 1;
            if (c >= 8'hC2 && c <= 8'hDF) return 2;
            if (c >= 8'hE0 && c <= 8'hEF) return 3;
            if (c >= 8'hF0 && c <= 8'hF4) return 4;
            return 0;
        endfunction

        function bit tail_ok(logic [7:0] lead, int k, logic [7:0] b);
            if (b[7:6] != 2'b10) return 0;
            if (k == 1) begin
                if (lead == 8'hE0 && b < 8'hA0) return 0;
                if (lead == 8'hED && b >= 8'hA0) return 0;
                if (lead == 8'hF0 && b < 8'h90) return 0;
                if (lead == 8'hF4 && b >= 8'h90) return 0;
            end
            return 1;
        endfunction

        function void add_byte(logic [7:0] b, logic repl);
            utf8s_out_t r;
            r.out_byte         = b;
            r.from_replacement = repl;
            r.run_last         = 1'b0;
            r.string_end       = 1'b0;
            fresh.insert(fresh.size(), r);
        endfunction

        function void add_replacement();
            add_byte(REPL_B0, 1'b1);
            add_byte(REPL_B1, 1'b1);
            add_byte(REPL_B2, 1'b1);
        endfunction

        // Predict the bytes caused by one accepted word.
        function void note_input(utf8s_in_t w);
            logic [7:0] seq[4];
            int         n;
            int         pos;
            int         len;
            int         avail;
            int         lim;
            bit         bad;
            logic [7:0] c;
            n   = 0;
            pos = 0;
            fresh.delete();
            for (int k = 0; k < held_n; k++) seq[k] = held[k];
            seq[held_n] = w.in_byte;
            n = held_n + 1;
            while (pos < n) begin
                c     = seq[pos];
                len   = seq_len(c);
                avail = n - pos;
                if (len == 1) begin
                    add_byte(c, 1'b0);
                    pos++;
                    continue;
                end
                if (len == 0) begin
                    add_replacement();
                    pos++;
                    continue;
                end
                lim = (avail < len) ? avail : len;
                bad = 0;
                for (int k = 1; k < lim; k++) begin
                    if (!bad && !tail_ok(c, k, seq[pos + k])) bad = 1;
                end
                if (bad) begin
                    add_replacement();
                    pos++;
                end else if (avail >= len) begin
                    for (int k = 0; k < len; k++) add_byte(seq[pos + k], 1'b0);
                    pos += len;
                end else if (w.is_final) begin
                    add_replacement();
                    pos++;
                end else begin
                    break;
                end
            end
            held   = '{default: 8'h00};
            held_n = 0;
            while (pos < n && held_n < 3) begin
                held[held_n] = seq[pos];
                held_n++;
                pos++;
            end
            if (fresh.size() > 0) begin
                fresh[fresh.size() - 1].run_last   = 1'b1;
                fresh[fresh.size() - 1].string_end = w.is_final;
            end
            foreach (fresh[i]) expected_q.insert(expected_q.size(), fresh[i]);
        endfunction

        function void check_result(utf8s_out_t got);
            utf8s_out_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected byte %h", got.out_byte));
                return;
            end
            exp = expected_q.pop_front();
            if (got.out_byte !== exp.out_byte)
                report($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
            if (got.from_replacement !== exp.from_replacement)
                report($sformatf("from_replacement %b, expected %b on byte %h",
                                 got.from_replacement, exp.from_replacement, exp.out_byte));
            if (got.run_last !== exp.run_last)
                report($sformatf("run_last %b, expected %b on byte %h",
                                 got.run_last, exp.run_last, exp.out_byte));
            if (got.string_end !== exp.string_end)
                report($sformatf("string_end %b, expected %b on byte %h",
                                 got.string_end, exp.string_end, exp.out_byte));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    utf8s_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    utf8s_out_t m_data;

    utf8_scoreboard sb;
    logic [7:0]     str_bytes[$];
    int             sent_words;
    bit             calm;
    bit             held_off;
    int             cycles;

    utf8_sanitizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Result side: random stalls, one long hold-off that backs up the block.
    initial begin
        m_ready  = 1'b0;
        held_off = 0;
        repeat (3) @(posedge aclk);
        forever begin
            if (!held_off && sent_words >= HOLD_AT) begin
                held_off = 1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(logic [7:0] b, logic fin);
        utf8s_in_t w;
        w.in_byte  = b;
        w.is_final = fin;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        sent_words++;
        if (sent_words >= CALM_AFTER) calm = 1;
    endtask

    task automatic send_string();
        foreach (str_bytes[i]) send_word(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    // One character: mostly well-formed, sometimes corrupted, cut short or raw noise.
    function automatic void add_char();
        logic [20:0] cp;
        logic [7:0]  ch[4];
        int          nb;
        int          kind;
        kind = $urandom_range(0, 99);
        if (kind < 7) begin
            str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 3))
            0: begin
                cp    = 21'($urandom_range(0, 'h7F));
                ch[0] = cp[7:0];
                nb    = 1;
            end
            1: begin
                cp    = 21'($urandom_range('h80, 'h7FF));
                ch[0] = {3'b110, cp[10:6]};
                ch[1] = {2'b10, cp[5:0]};
                nb    = 2;
            end
            2: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
                ch[0] = {4'b1110, cp[15:12]};
                ch[1] = {2'b10, cp[11:6]};
                ch[2] = {2'b10, cp[5:0]};
                nb    = 3;
            end
            default: begin
                cp    = 21'($urandom_range('h10000, 'h10FFFF));
                ch[0] = {5'b11110, cp[20:18]};
                ch[1] = {2'b10, cp[17:12]};
                ch[2] = {2'b10, cp[11:6]};
                ch[3] = {2'b10, cp[5:0]};
                nb    = 4;
            end
        endcase
        if (nb > 1 && kind < 17) ch[$urandom_range(1, nb - 1)] = 8'($urandom_range(0, 255));
        else if (nb > 1 && kind < 27) nb = $urandom_range(1, nb - 1);
        for (int k = 0; k < nb; k++) str_bytes.insert(str_bytes.size(), ch[k]);
    endfunction

    initial begin
        sb         = new();
        sent_words = 0;
        calm       = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ASCII extremes, invalid leads, smallest two-byte sequence
        str_bytes = '{8'h00, 8'hFF, 8'hC1, 8'h80, 8'hC2, 8'h80, 8'h7F};
        send_string();
        // overlong, surrogate, overlong four-byte, above U+10FFFF
        str_bytes = '{8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90};
        send_string();
        // largest code point, then a bad continuation
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hDF, 8'hC0};
        send_string();
        // broken four-byte lead, then a sequence cut off by the end
        str_bytes = '{8'hF0, 8'h90, 8'h80, 8'hE2, 8'h82};
        send_string();

        while (sent_words < WORD_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) add_char();
            end
            send_string();
        end
        s_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: utf8_sanitizer.f
hw/rtl/utf8s_pkg.sv
hw/rtl/utf8s_datapath.sv
hw/rtl/utf8s_ctrl.sv
hw/rtl/utf8_sanitizer.sv
bench/utf8_sanitizer_tb.sv
